// ----- sv/motion_gated_alpha_beta_smoother_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the motion-gated alpha-beta smoother
// Same-cycle and next-cycle implication checks, disabled while reset is high.
// -----------------------------------------------------------------------------
`ifndef MOTION_GATED_ALPHA_BETA_SMOOTHER_ASSERT_SVH
`define MOTION_GATED_ALPHA_BETA_SMOOTHER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MGAB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MGAB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mgab_pkg.sv -----
// -----------------------------------------------------------------------------
// mgab_pkg
// Shared types and constants of the motion-gated alpha-beta smoother.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mgab_pkg;

   localparam int ELEM_W   = 5;
   localparam int THRESH_W = 21;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 3;

   localparam logic [THRESH_W-1:0] SUM_MAX = {THRESH_W{1'b1}};

   // Q1.15 gains: 0.5 on x, 0.5858 on newer, -0.0858 on older
   localparam int FRAC_BITS  = 15;
   localparam int X_SHIFT    = 14;
   localparam int COEF_NEWER = 19195;
   localparam int COEF_OLDER = 2811;
   localparam int ROUND_HALF = 16384;

   localparam logic [ELEM_W-1:0]   ELEM_RESET   = 5'd16;
   localparam logic [THRESH_W-1:0] THRESH_RESET = '0;

   localparam logic [1:0] WARM_FULL = 2'd2;
   localparam logic [1:0] WARM_ZERO = 2'd0;
   localparam logic [1:0] WARM_ONE  = 2'd1;

   localparam logic REG_ELEMENTS  = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load_en;
      logic       rotate;
      logic       sum_clr;
      logic       sum_en;
      logic       mul_en;
      logic       out_fire;
      logic       out_last;
      logic       hist_upd;
      logic       busy;
      logic [1:0] warm;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- sv/mgab_cell.sv -----
// -----------------------------------------------------------------------------
// mgab_cell
// One element slot: current sample plus two history samples, ring-shifted.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgab_cell
   import mgab_pkg::*;
#(
   parameter int W = 16
) (
   input  wire                 clock,
   input  wire                 rotate,
   input  wire                 load_en,
   input  wire signed [W-1:0]  sample,
   input  wire signed [W-1:0]  fb_next,
   input  wire signed [W-1:0]  nw_next,
   input  wire signed [W-1:0]  od_next,
   output logic signed [W-1:0] fb_q,
   output logic signed [W-1:0] nw_q,
   output logic signed [W-1:0] od_q
);

   logic signed [W-1:0] fb_ff;
   logic signed [W-1:0] nw_ff;
   logic signed [W-1:0] od_ff;

   always_ff @(posedge clock) begin
      if (rotate) begin
         fb_ff <= fb_next;
         nw_ff <= nw_next;
         od_ff <= od_next;
      end else if (load_en) begin
         fb_ff <= sample;
      end
   end

   assign fb_q = fb_ff;
   assign nw_q = nw_ff;
   assign od_q = od_ff;

endmodule

`default_nettype wire

// ----- sv/mgab_damp.sv -----
// -----------------------------------------------------------------------------
// mgab_damp
// Damping datapath: registered products, then sum, round and saturate.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgab_damp
   import mgab_pkg::*;
#(
   parameter int W = 16
) (
   input  wire                 clock,
   input  wire                 mul_en,
   input  wire signed [W-1:0]  x,
   input  wire signed [W-1:0]  newer,
   input  wire signed [W-1:0]  older,
   output logic signed [W-1:0] result
);

   localparam int PW = W + 16;
   localparam int AW = W + 18;
   localparam logic signed [AW-1:0] SAT_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

   logic signed [PW-1:0] px_ff, pn_ff, po_ff;
   logic signed [PW-1:0] px_in, pn_in, po_in;
   logic signed [AW-1:0] acc;
   logic signed [AW-1:0] quo;

   assign px_in = PW'(x) <<< X_SHIFT;
   assign pn_in = PW'(newer) * PW'(COEF_NEWER);
   assign po_in = PW'(older) * PW'(COEF_OLDER);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         px_ff <= px_in;
         pn_ff <= pn_in;
         po_ff <= po_in;
      end
   end

   // arithmetic shift gives floor, so the half bias rounds ties upward
   always_comb begin
      acc = AW'(px_ff) + AW'(pn_ff) - AW'(po_ff) + AW'(ROUND_HALF);
      quo = acc >>> FRAC_BITS;
      if (quo > SAT_HI) begin
         result = SAT_HI[W-1:0];
      end else if (quo < SAT_LO) begin
         result = SAT_LO[W-1:0];
      end else begin
         result = quo[W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- sv/mgab_ctrl.sv -----
// -----------------------------------------------------------------------------
// mgab_ctrl
// Sequencer: sample capture, difference pass and emit pass over the ring.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mgab_ctrl
   import mgab_pkg::*;
#(
   parameter int M = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire [$clog2(M+1)-1:0]                 n_eff,
   output ctrl_type                              cs,
   output logic [((M > 1) ? $clog2(M) : 1)-1:0]  slot
);

   localparam int IDX_W = (M > 1) ? $clog2(M) : 1;
   localparam logic [IDX_W-1:0] STEP_END = IDX_W'(M - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [1:0]       warm_ff, warm_in;

   logic close, step_active, step_last, done;

   assign close       = (32'(slot_ff) + 32'd1) >= 32'(n_eff);
   assign step_active = 32'(step_ff) < 32'(n_eff);
   assign step_last   = step_ff == STEP_END;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && close) begin
               state_in = (warm_ff == WARM_FULL) ? ST_SUM : ST_MUL;
            end
         end
         ST_SUM: begin
            if (step_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_active) begin
               state_in = ST_OUT;
            end else if (step_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            state_in = step_last ? ST_IDLE : ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cs      = '0;
      cs.warm = warm_ff;
      cs.busy = state_ff != ST_IDLE;
      done    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cs.load_en = start;
            cs.sum_clr = start && close;
         end
         ST_SUM: begin
            cs.rotate = 1'b1;
            cs.sum_en = step_active;
         end
         ST_MUL: begin
            cs.mul_en = step_active;
            cs.rotate = !step_active;
            done      = !step_active && step_last;
         end
         ST_OUT: begin
            cs.out_fire = 1'b1;
            cs.rotate   = 1'b1;
            cs.hist_upd = 1'b1;
            cs.out_last = (32'(step_ff) + 32'd1) == 32'(n_eff);
            done        = step_last;
         end
         default: begin
            cs.busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      slot_in = slot_ff;
      if (cs.load_en) begin
         slot_in = close ? '0 : slot_ff + 1'b1;
      end
      step_in = step_ff;
      if (state_ff == ST_IDLE) begin
         step_in = '0;
      end else if (cs.rotate) begin
         step_in = step_last ? '0 : step_ff + 1'b1;
      end
      warm_in = warm_ff;
      if (done && warm_ff != WARM_FULL) begin
         warm_in = warm_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         step_ff  <= '0;
         warm_ff  <= WARM_ZERO;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         step_ff  <= step_in;
         warm_ff  <= warm_in;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ----- sv/motion_gated_alpha_beta_smoother.sv -----
// -----------------------------------------------------------------------------
// motion_gated_alpha_beta_smoother
// Frame smoother with a fixed critically damped alpha-beta gain, gated by
// the sum of absolute differences against the previous output frame.
// -----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+----------------------------------
//  request  | start & !busy                 | req_sample
//  response | rsp_valid (one cycle, no stall)| rsp_value, rsp_last_of_frame,
//           |                               | rsp_damped
//  csr      | psel & penable & pwrite       | paddr, pwdata / prdata
//
//  A sample beat is taken when start is seen while idle. The beat that
//  closes a frame starts a difference pass over every cell (skipped in the
//  two warm-up frames), then an emit pass that spends a multiply and an
//  output step on each frame element and a single rotate on each unused
//  cell; the ring length of the cell chain sets both passes.
//  Results leave through an output register in the cycle after computation.
//  Reset inits control, CSRs, sum and rsp_valid; history is undefined until written.
//  The receiver cannot stall; busy holds off new samples during the passes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motion_gated_alpha_beta_smoother
   import mgab_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   // request
   input  wire                           start,
   output logic                          busy,
   input  wire signed [SAMPLE_WIDTH-1:0] req_sample,
   // response
   output logic                          rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_value,
   output logic                          rsp_last_of_frame,
   output logic                          rsp_damped,
   // csr
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire [ADDR_W-1:0]              paddr,
   input  wire [CSR_W-1:0]               pwdata,
   output logic [CSR_W-1:0]              prdata,
   output logic                          pready
);

`include "motion_gated_alpha_beta_smoother_assert.svh"

   localparam int M     = MAX_ELEMENTS;
   localparam int W     = SAMPLE_WIDTH;
   localparam int IDX_W = (M > 1) ? $clog2(M) : 1;
   localparam int CNT_W = $clog2(M + 1);
   localparam int SAW   = (W + 2 > THRESH_W + 1) ? W + 2 : THRESH_W + 1;

   // ---------------------------------------------------------------- csr
   logic [ELEM_W-1:0]   elem_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic                csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff   <= ELEM_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_ELEMENTS) begin
            elem_ff <= pwdata[ELEM_W-1:0];
         end else begin
            thresh_ff <= pwdata[THRESH_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_THRESHOLD) begin
         prdata = CSR_W'(thresh_ff);
      end else begin
         prdata = CSR_W'(elem_ff);
      end
   end

   // frame length clamped to 1..MAX_ELEMENTS
   logic [CNT_W-1:0] n_eff;
   always_comb begin
      if (elem_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(elem_ff) > 32'(M)) begin
         n_eff = CNT_W'(M);
      end else begin
         n_eff = CNT_W'(elem_ff);
      end
   end

   // ---------------------------------------------------------------- control
   ctrl_type         cs;
   logic [IDX_W-1:0] slot;

   mgab_ctrl #(.M(M)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .n_eff (n_eff),
      .cs    (cs),
      .slot  (slot)
   );

   assign busy = cs.busy;

   // ---------------------------------------------------------------- cell ring
   // Cell 0 is the head; the ring shifts toward it and the head wraps to the
   // tail, carrying updated history during the emit pass.
   logic signed [W-1:0] fb_q [M];
   logic signed [W-1:0] nw_q [M];
   logic signed [W-1:0] od_q [M];
   logic signed [W-1:0] fb_nx [M];
   logic signed [W-1:0] nw_nx [M];
   logic signed [W-1:0] od_nx [M];

   logic signed [W-1:0] out_v;
   logic signed [W-1:0] tail_nw, tail_od;

   always_comb begin
      tail_nw = nw_q[0];
      tail_od = od_q[0];
      if (cs.hist_upd) begin
         case (cs.warm)
            WARM_ZERO: tail_od = out_v;
            WARM_ONE:  tail_nw = out_v;
            default: begin
               tail_od = nw_q[0];
               tail_nw = out_v;
            end
         endcase
      end
   end

   for (genvar k = 0; k < M; k++) begin : g_cell
      if (k == M - 1) begin : g_tail
         assign fb_nx[k] = fb_q[0];
         assign nw_nx[k] = tail_nw;
         assign od_nx[k] = tail_od;
      end else begin : g_body
         assign fb_nx[k] = fb_q[k+1];
         assign nw_nx[k] = nw_q[k+1];
         assign od_nx[k] = od_q[k+1];
      end

      mgab_cell #(.W(W)) u_cell (
         .clock   (clock),
         .rotate  (cs.rotate),
         .load_en (cs.load_en && (slot == IDX_W'(k))),
         .sample  (req_sample),
         .fb_next (fb_nx[k]),
         .nw_next (nw_nx[k]),
         .od_next (od_nx[k]),
         .fb_q    (fb_q[k]),
         .nw_q    (nw_q[k]),
         .od_q    (od_q[k])
      );
   end

   // ---------------------------------------------------------------- difference sum
   logic [THRESH_W-1:0] sum_ff, sum_in;
   logic signed [W:0]   diff;
   logic [W:0]          absd;
   logic [SAW-1:0]      sum_wide;

   always_comb begin
      diff     = (W+1)'(fb_q[0]) - (W+1)'(nw_q[0]);
      absd     = diff[W] ? (W+1)'(-diff) : diff;
      sum_wide = SAW'(sum_ff) + SAW'(absd);
      sum_in   = sum_ff;
      if (cs.sum_clr) begin
         sum_in = '0;
      end else if (cs.sum_en) begin
         sum_in = (sum_wide > SAW'(SUM_MAX)) ? SUM_MAX : sum_wide[THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // steady in the emit pass if threshold is not written; sum holds then
   logic damp_on;
   assign damp_on = (cs.warm == WARM_FULL) && (sum_ff < thresh_ff);

   // ---------------------------------------------------------------- damping
   logic signed [W-1:0] damp_res;

   mgab_damp #(.W(W)) u_damp (
      .clock  (clock),
      .mul_en (cs.mul_en),
      .x      (fb_q[0]),
      .newer  (nw_q[0]),
      .older  (od_q[0]),
      .result (damp_res)
   );

   assign out_v = damp_on ? damp_res : fb_q[0];

   // ---------------------------------------------------------------- result register
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_value_ff;
   logic                rsp_last_ff;
   logic                rsp_damped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cs.out_fire;
      end
      rsp_value_ff  <= out_v;
      rsp_last_ff   <= cs.out_last;
      rsp_damped_ff <= damp_on;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign rsp_damped        = rsp_damped_ff;

   // ---------------------------------------------------------------- checks
   `MGAB_ASSERT_SAME(a_beat_from_pass, clock, reset, rsp_valid, $past(busy), "result beat outside a pass")
   `MGAB_ASSERT_NEXT(a_gap_after_frame, clock, reset, rsp_valid && rsp_last_of_frame, !rsp_valid, "beat right after frame end")
   `MGAB_ASSERT_SAME(a_damp_warm, clock, reset, rsp_valid && rsp_damped, cs.warm == WARM_FULL, "damped during warm-up")
   `MGAB_ASSERT_NEXT(a_warm_sticks, clock, reset, cs.warm == WARM_FULL, cs.warm == WARM_FULL, "warm-up count left full")

endmodule

`default_nettype wire
